// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by pid_speed_controller_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/pidsc_pkg.sv =====
`timescale 1ns / 1ps

package pidsc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KP_GAIN        = 3'd0,
        REG_KI_GAIN        = 3'd1,
        REG_KD_GAIN        = 3'd2,
        REG_ERROR_DEADBAND = 3'd3,
        REG_P_LIMIT        = 3'd4,
        REG_I_LIMIT        = 3'd5,
        REG_D_LIMIT        = 3'd6,
        REG_OUTPUT_LIMIT   = 3'd7
    } cfg_reg_t;

    // reset values of the configuration registers
    localparam logic [15:0] KP_GAIN_RST        = 16'd7680;
    localparam logic [15:0] KI_GAIN_RST        = 16'd128;
    localparam logic [15:0] KD_GAIN_RST        = 16'd2560;
    localparam logic [15:0] ERROR_DEADBAND_RST = 16'd2;
    localparam logic [14:0] P_LIMIT_RST        = 15'd15000;
    localparam logic [14:0] I_LIMIT_RST        = 15'd4000;
    localparam logic [14:0] D_LIMIT_RST        = 15'd5000;
    localparam logic [14:0] OUTPUT_LIMIT_RST   = 15'd20000;

    // x/6 as (x * 43691) >> 18, exact for x below 2^17
    localparam logic [15:0] DIV6_MUL   = 16'd43691;
    localparam int          DIV6_SHIFT = 18;

    // live configuration
    typedef struct packed {
        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [15:0] kd_gain;
        logic [15:0] error_deadband;
        logic [14:0] p_limit;
        logic [14:0] i_limit;
        logic [14:0] d_limit;
        logic [14:0] output_limit;
    } cfg_t;

    // gain products of one word, ahead of the control law stage
    typedef struct packed {
        logic signed [34:0] p_prod;
        logic signed [34:0] i_prod;
        logic signed [35:0] d_prod;
        logic               err_pos;
        logic               moving;
    } prod_t;

endpackage

// ===== rtl/pidsc_law.sv =====
`timescale 1ns / 1ps

// Control law: term scaling and saturation, integral update, compensation,
// slew limit and output clamp.
module pidsc_law #(
    parameter int SLEW_LIMIT       = 5000,
    parameter int OUT_COMPENSATION = 0
) (
    input  pidsc_pkg::prod_t     prod,
    input  pidsc_pkg::cfg_t      cfg,
    input  logic signed [23:0]   integral_acc,
    input  logic signed [15:0]   previous_output,
    output logic signed [23:0]   integral_next,
    output logic signed [15:0]   raw
);
    import pidsc_pkg::*;

    localparam logic signed [18:0] SLEW_S = 19'(SLEW_LIMIT);
    localparam logic signed [18:0] COMP_S = 19'(OUT_COMPENSATION);

    logic signed [26:0] p_shr;
    logic signed [26:0] p_lim;
    logic signed [15:0] p_term;
    logic signed [35:0] acc_sum;
    logic signed [35:0] i_lim;
    logic signed [15:0] i_term;
    logic signed [27:0] d_shr;
    logic signed [27:0] d_lim;
    logic signed [15:0] d_term;
    logic signed [18:0] sum;
    logic signed [18:0] sum_c;
    logic signed [18:0] prev_ext;
    logic signed [19:0] diff;
    logic        [19:0] diff_mag;
    logic signed [18:0] sum_s;
    logic signed [18:0] o_lim;

    // P term: floor shift of the product, then symmetric clamp
    always_comb
    begin
        p_shr = $signed(prod.p_prod[34:8]);
        p_lim = $signed({12'd0, cfg.p_limit});
        if (p_shr > p_lim)
            p_term = p_lim[15:0];
        else if (p_shr < -p_lim)
            p_term = 16'(-p_lim);
        else
            p_term = p_shr[15:0];
    end

    // integral accumulate and clamp, integer part is the I term
    always_comb
    begin
        acc_sum = {{12{integral_acc[23]}}, integral_acc} + {prod.i_prod[34], prod.i_prod};
        i_lim   = $signed({13'd0, cfg.i_limit, 8'd0});
        if (acc_sum > i_lim)
            integral_next = i_lim[23:0];
        else if (acc_sum < -i_lim)
            integral_next = 24'(-i_lim);
        else
            integral_next = acc_sum[23:0];
        i_term = integral_next[23:8];
    end

    // D term
    always_comb
    begin
        d_shr = $signed(prod.d_prod[35:8]);
        d_lim = $signed({13'd0, cfg.d_limit});
        if (d_shr > d_lim)
            d_term = d_lim[15:0];
        else if (d_shr < -d_lim)
            d_term = 16'(-d_lim);
        else
            d_term = d_shr[15:0];
    end

    // sum, compensation, slew limit while moving, output clamp
    always_comb
    begin
        sum      = 19'(p_term) + 19'(i_term) + 19'(d_term);
        sum_c    = prod.err_pos ? (sum - COMP_S) : (sum + COMP_S);
        prev_ext = 19'(previous_output);
        diff     = 20'(sum_c) - 20'(prev_ext);
        diff_mag = diff[19] ? 20'(-diff) : diff;
        if (diff_mag > 20'(SLEW_S) && prod.moving)
            sum_s = (sum_c > prev_ext) ? (prev_ext + SLEW_S) : (prev_ext - SLEW_S);
        else
            sum_s = sum_c;
        o_lim = $signed({4'd0, cfg.output_limit});
        if (sum_s > o_lim)
            raw = o_lim[15:0];
        else if (sum_s < -o_lim)
            raw = 16'(-o_lim);
        else
            raw = sum_s[15:0];
    end

endmodule

// ===== rtl/pid_speed_controller_unit.sv =====
// PID speed controller with deadband, per-term saturation and slew limit.
// One word of measured and target speed goes in, one word of drive_value
// (raw_drive / 6, toward zero) and raw_drive comes out. There are five
// register stages: input, deadbanded error, gain products, raw drive after
// the control law, and the divided output word. Previous error is updated
// as a word enters the product stage. Integral and previous output are
// updated as it enters the raw drive stage. out_valid is registered in the
// output stage, and a new word is taken every cycle while the output is
// not stalled. A stall on the output backs up through the stages, and bubbles
// collapse. Registers are to be written through the cfg port (always ready)
// only while no word is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module pid_speed_controller_unit #(
    parameter int SLEW_LIMIT       = 5000,
    parameter int OUT_COMPENSATION = 0,
    parameter int FEEDBACK_DIV     = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] measured_speed,
    input  logic signed [15:0] speed_setpoint,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] drive_value,
    output logic signed [15:0] raw_drive,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import pidsc_pkg::*;

    // x / FEEDBACK_DIV as (x * RATIO_MUL) >> 21, exact for x below 2^17
    localparam int          RATIO_SHIFT = 21;
    localparam int          RATIO_MUL   = ((1 << RATIO_SHIFT) + FEEDBACK_DIV - 1) / FEEDBACK_DIV;
    localparam logic [21:0] RATIO_MUL_V = 22'(RATIO_MUL);

    cfg_t cfg_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;

    logic signed [15:0] meas1_reg, targ1_reg;
    logic signed [17:0] err2_reg;
    logic               moving2_reg;
    prod_t              prod3_reg;
    logic signed [15:0] raw4_reg;
    logic signed [13:0] drive_reg;
    logic signed [15:0] raw_out_reg;

    logic signed [23:0] integral_acc_reg;
    logic signed [17:0] previous_error_reg;
    logic signed [15:0] previous_output_reg;

    logic        [16:0] meas_mag;
    logic        [38:0] scaled_prod;
    logic        [16:0] scaled_mag;
    logic signed [17:0] scaled;
    logic signed [17:0] err_raw;
    logic        [17:0] err_neg;
    logic        [16:0] err_mag;
    logic signed [17:0] err_next;
    logic signed [18:0] err_diff;
    prod_t              prod_next;
    logic signed [23:0] integral_next;
    logic signed [15:0] raw_next;
    logic        [15:0] raw_neg;
    logic        [14:0] raw_mag;
    logic        [30:0] div6_prod;
    logic        [12:0] div6_q;
    logic signed [13:0] drive_next;

    // stage handshake, bubbles collapse
    assign rdy_out   = !out_valid_reg || !out_stall;
    assign rdy4      = !v4_reg || rdy_out;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_stall  = !rdy1;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy_out)
                out_valid_reg <= v4_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain        <= KP_GAIN_RST;
            cfg_reg.ki_gain        <= KI_GAIN_RST;
            cfg_reg.kd_gain        <= KD_GAIN_RST;
            cfg_reg.error_deadband <= ERROR_DEADBAND_RST;
            cfg_reg.p_limit        <= P_LIMIT_RST;
            cfg_reg.i_limit        <= I_LIMIT_RST;
            cfg_reg.d_limit        <= D_LIMIT_RST;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KP_GAIN:        cfg_reg.kp_gain        <= cfg_data;
                REG_KI_GAIN:        cfg_reg.ki_gain        <= cfg_data;
                REG_KD_GAIN:        cfg_reg.kd_gain        <= cfg_data;
                REG_ERROR_DEADBAND: cfg_reg.error_deadband <= cfg_data;
                REG_P_LIMIT:        cfg_reg.p_limit        <= cfg_data[14:0];
                REG_I_LIMIT:        cfg_reg.i_limit        <= cfg_data[14:0];
                REG_D_LIMIT:        cfg_reg.d_limit        <= cfg_data[14:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= cfg_data[14:0];
                default:            ;
            endcase
        end
    end

    // stage 1: input word
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            meas1_reg <= measured_speed;
            targ1_reg <= speed_setpoint;
        end
    end

    // scaled measurement, error and deadband
    always_comb
    begin
        meas_mag    = meas1_reg[15] ? 17'(-17'(meas1_reg)) : 17'(meas1_reg);
        scaled_prod = 39'(meas_mag) * 39'(RATIO_MUL_V);
        scaled_mag  = scaled_prod[37:21];
        scaled      = meas1_reg[15] ? 18'(-18'(scaled_mag)) : 18'(scaled_mag);
        err_raw     = 18'(targ1_reg) - scaled;
        err_neg     = 18'(-err_raw);
        err_mag     = err_raw[17] ? err_neg[16:0] : err_raw[16:0];
        err_next    = (err_mag < {1'b0, cfg_reg.error_deadband}) ? '0 : err_raw;
    end

    // stage 2: error
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            err2_reg    <= err_next;
            moving2_reg <= |meas1_reg;
        end
    end

    // gain products
    always_comb
    begin
        err_diff          = 19'(err2_reg) - 19'(previous_error_reg);
        prod_next.p_prod  = $signed({1'b0, cfg_reg.kp_gain}) * err2_reg;
        prod_next.i_prod  = $signed({1'b0, cfg_reg.ki_gain}) * err2_reg;
        prod_next.d_prod  = $signed({1'b0, cfg_reg.kd_gain}) * err_diff;
        prod_next.err_pos = !err2_reg[17] && (|err2_reg);
        prod_next.moving  = moving2_reg;
    end

    // stage 3: products; previous error follows each word into this stage
    always_ff @(posedge clk)
    begin
        if (rdy3)
            prod3_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            previous_error_reg <= '0;
        else if (rdy3 && v2_reg)
            previous_error_reg <= err2_reg;
    end

    pidsc_law #(
        .SLEW_LIMIT       (SLEW_LIMIT),
        .OUT_COMPENSATION (OUT_COMPENSATION)
    ) u_law (
        .prod            (prod3_reg),
        .cfg             (cfg_reg),
        .integral_acc    (integral_acc_reg),
        .previous_output (previous_output_reg),
        .integral_next   (integral_next),
        .raw             (raw_next)
    );

    // stage 4: raw drive and controller state
    always_ff @(posedge clk)
    begin
        if (rdy4)
            raw4_reg <= raw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_acc_reg    <= '0;
            previous_output_reg <= '0;
        end
        else if (rdy4 && v3_reg)
        begin
            integral_acc_reg    <= integral_next;
            previous_output_reg <= raw_next;
        end
    end

    // divide by six, toward zero
    always_comb
    begin
        raw_neg    = 16'(-raw4_reg);
        raw_mag    = raw4_reg[15] ? raw_neg[14:0] : raw4_reg[14:0];
        div6_prod  = 31'(raw_mag) * 31'(DIV6_MUL);
        div6_q     = div6_prod[DIV6_SHIFT +: 13];
        drive_next = raw4_reg[15] ? 14'(-14'(div6_q)) : 14'(div6_q);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            drive_reg   <= drive_next;
            raw_out_reg <= raw4_reg;
        end
    end

    assign drive_value = drive_reg;
    assign raw_drive   = raw_out_reg;

    // checks
    logic signed [16:0] out_lim_s;
    logic signed [17:0] div_rem;
    logic               raw_in_lim;
    logic               div6_ok;
    logic               pipe_empty;

    assign out_lim_s  = $signed({2'd0, cfg_reg.output_limit});
    assign div_rem    = 18'(raw_drive) - 18'(drive_value) * 18'sd6;
    assign raw_in_lim = (17'(raw_drive) <= out_lim_s) && (17'(raw_drive) >= -out_lim_s);
    assign div6_ok    = (div_rem > -18'sd6) && (div_rem < 18'sd6);
    assign pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg || out_valid_reg);

`include "assert_macros.svh"

    `ASSERT_CLK(a_raw_in_limit, out_valid |-> raw_in_lim, "raw drive outside output limit")
    `ASSERT_CLK(a_div6_consistent, out_valid |-> div6_ok, "drive value not raw drive over six")
    `ASSERT_NEVER(a_empty_stalls, pipe_empty && in_stall, "empty pipeline stalls input")

endmodule

// ===== dv/pidsc_checker.sv =====
`timescale 1ns / 1ps

module pidsc_checker #(
    parameter int SLEW_LIMIT       = 5000,
    parameter int OUT_COMPENSATION = 0,
    parameter int FEEDBACK_DIV     = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] measured_speed,
    input  logic signed [15:0] speed_setpoint,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [13:0] drive_value,
    input  logic signed [15:0] raw_drive,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import pidsc_pkg::*;

    // one expected output word
    typedef struct {
        logic signed [13:0] drive;
        logic signed [15:0] raw;
    } drive_word_t;

    drive_word_t        drive_q[$];

    // shadow of the register file and of the controller state
    cfg_t               shadow_cfg;
    logic signed [23:0] integ_acc;
    logic signed [17:0] last_err;
    logic signed [15:0] last_raw;

    function automatic longint clamp_mag(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // one control tick: returns the drive word and advances the shadow state
    function automatic drive_word_t control_tick(input logic signed [15:0] meas,
                                                 input logic signed [15:0] targ);
        drive_word_t w;
        longint      err;
        longint      mag;
        longint      p_term;
        longint      i_sum;
        longint      d_term;
        longint      total;
        longint      step;
        longint      raw;

        err = longint'(targ) - longint'(meas) / FEEDBACK_DIV;
        mag = (err < 0) ? -err : err;
        if (mag < longint'(shadow_cfg.error_deadband))
            err = 0;

        // products floor towards minus infinity via arithmetic shift
        p_term = clamp_mag((longint'(shadow_cfg.kp_gain) * err) >>> 8,
                           longint'(shadow_cfg.p_limit));
        i_sum  = clamp_mag(longint'(integ_acc) + longint'(shadow_cfg.ki_gain) * err,
                           longint'(shadow_cfg.i_limit) * 256);
        d_term = clamp_mag((longint'(shadow_cfg.kd_gain) * (err - longint'(last_err))) >>> 8,
                           longint'(shadow_cfg.d_limit));

        total = p_term + (i_sum >>> 8) + d_term;
        if (err > 0)
            total = total - OUT_COMPENSATION;
        else
            total = total + OUT_COMPENSATION;

        // slew limit only while the motor turns
        step = total - longint'(last_raw);
        if (step < 0)
            step = -step;
        if (step > SLEW_LIMIT && meas != 0)
            total = (total > longint'(last_raw)) ? longint'(last_raw) + SLEW_LIMIT
                                                 : longint'(last_raw) - SLEW_LIMIT;

        raw = clamp_mag(total, longint'(shadow_cfg.output_limit));

        integ_acc = i_sum[23:0];
        last_err  = err[17:0];
        last_raw  = raw[15:0];

        w.raw   = raw[15:0];
        w.drive = 14'(raw / 6);
        return w;
    endfunction

    // watch the three channels; outputs first, since a word in flight is older
    always @(posedge clk or negedge rst_n)
    begin : monitor
        drive_word_t exp_w;
        if (!rst_n)
        begin
            shadow_cfg.kp_gain        = KP_GAIN_RST;
            shadow_cfg.ki_gain        = KI_GAIN_RST;
            shadow_cfg.kd_gain        = KD_GAIN_RST;
            shadow_cfg.error_deadband = ERROR_DEADBAND_RST;
            shadow_cfg.p_limit        = P_LIMIT_RST;
            shadow_cfg.i_limit        = I_LIMIT_RST;
            shadow_cfg.d_limit        = D_LIMIT_RST;
            shadow_cfg.output_limit   = OUTPUT_LIMIT_RST;
            integ_acc  = '0;
            last_err   = '0;
            last_raw   = '0;
            drive_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    $display("%0t: unexpected drive word: expected none, actual %0d / %0d",
                             $time, drive_value, raw_drive);
                    fail_count++;
                end
                else
                begin
                    exp_w = drive_q.pop_front();
                    if (drive_value !== exp_w.drive)
                    begin
                        $display("%0t: drive_value mismatch: expected %0d, actual %0d",
                                 $time, exp_w.drive, drive_value);
                        fail_count++;
                    end
                    if (raw_drive !== exp_w.raw)
                    begin
                        $display("%0t: raw_drive mismatch: expected %0d, actual %0d",
                                 $time, exp_w.raw, raw_drive);
                        fail_count++;
                    end
                end
            end

            // register writes; limits keep 15 bits
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_KP_GAIN:        shadow_cfg.kp_gain        = cfg_data;
                    REG_KI_GAIN:        shadow_cfg.ki_gain        = cfg_data;
                    REG_KD_GAIN:        shadow_cfg.kd_gain        = cfg_data;
                    REG_ERROR_DEADBAND: shadow_cfg.error_deadband = cfg_data;
                    REG_P_LIMIT:        shadow_cfg.p_limit        = cfg_data[14:0];
                    REG_I_LIMIT:        shadow_cfg.i_limit        = cfg_data[14:0];
                    REG_D_LIMIT:        shadow_cfg.d_limit        = cfg_data[14:0];
                    REG_OUTPUT_LIMIT:   shadow_cfg.output_limit   = cfg_data[14:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                drive_q.push_back(control_tick(measured_speed, speed_setpoint));

            pending = drive_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pidsc_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int SLEW_LIMIT       = 5000;
    localparam int OUT_COMPENSATION = 0;
    localparam int FEEDBACK_DIV     = 1;
    localparam int WORDS_PER_PHASE  = 100;
    localparam int NUM_PHASES       = 7;
    localparam int PIPE_DEPTH       = 5;
    localparam int QUIET_LIMIT      = 3000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] measured_speed;
    logic signed [15:0] speed_setpoint;
    logic               out_valid;
    logic               out_stall;
    logic signed [13:0] drive_value;
    logic signed [15:0] raw_drive;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 quiet_cycles;
    logic signed [15:0] hold_target;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pid_speed_controller_unit #(
        .SLEW_LIMIT       (SLEW_LIMIT),
        .OUT_COMPENSATION (OUT_COMPENSATION),
        .FEEDBACK_DIV     (FEEDBACK_DIV)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured_speed (measured_speed),
        .speed_setpoint (speed_setpoint),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_value    (drive_value),
        .raw_drive      (raw_drive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    pidsc_checker #(
        .SLEW_LIMIT       (SLEW_LIMIT),
        .OUT_COMPENSATION (OUT_COMPENSATION),
        .FEEDBACK_DIV     (FEEDBACK_DIV)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured_speed (measured_speed),
        .speed_setpoint (speed_setpoint),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_value    (drive_value),
        .raw_drive      (raw_drive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: cycles without any word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // offer one speed word, with random gaps ahead of it
    task automatic send_word(input logic signed [15:0] meas, input logic signed [15:0] targ);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        measured_speed <= meas;
        speed_setpoint <= targ;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every expected word has come back
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [15:0] db,
                                input logic [15:0] pl, input logic [15:0] il,
                                input logic [15:0] dl, input logic [15:0] ol);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KI_GAIN, ki);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_ERROR_DEADBAND, db);
        write_reg(REG_P_LIMIT, pl);
        write_reg(REG_I_LIMIT, il);
        write_reg(REG_D_LIMIT, dl);
        write_reg(REG_OUTPUT_LIMIT, ol);
        cfg_valid <= 1'b0;
    endtask

    // random speed word: tracking near target, standstill, steady target,
    // full-scale error, or plain noise
    task automatic send_random;
        int                 sel;
        logic signed [15:0] meas;
        logic signed [15:0] targ;
        sel  = $urandom_range(9);
        meas = 16'($urandom);
        targ = 16'($urandom);
        if (sel < 3)
            targ = sat16(int'(meas) + int'($urandom_range(100)) - 50);
        else if (sel < 5)
            meas = 16'sd0;
        else if (sel < 7)
        begin
            targ = hold_target;
            meas = sat16(int'(hold_target) + int'($urandom_range(4000)) - 2000);
        end
        else if (sel == 7)
        begin
            meas = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            targ = ~meas;
        end
        send_word(meas, targ);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        measured_speed = '0;
        speed_setpoint = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_KP_GAIN;
        cfg_data       = '0;
        send_idle_pct  = 24;
        recv_stall_pct = 77;
        hold_target    = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words at reset configuration
        send_word(16'sd0, 16'sd0);
        send_word(16'sd0, 16'sd32767);
        send_word(16'sd0, -16'sd32768);
        send_word(-16'sd32768, 16'sd32767);
        send_word(16'sd32767, -16'sd32768);
        send_word(16'sd32767, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768);
        // deadband edges
        send_word(16'sd100, 16'sd101);
        send_word(16'sd100, 16'sd99);
        send_word(16'sd100, 16'sd102);
        send_word(16'sd100, 16'sd98);
        send_word(16'sd5, 16'sd5);
        // compensation sign: positive, zero and negative error
        send_word(-16'sd1, 16'sd40);
        send_word(16'sd40, 16'sd40);
        send_word(16'sd40, -16'sd1);
        // large steps with the motor turning, then at standstill, then a small step turning
        send_word(16'sd1000, 16'sd30000);
        send_word(-16'sd1000, -16'sd30000);
        send_word(16'sd0, -16'sd30000);
        send_word(16'sd0, 16'sd30000);
        send_word(16'sd7, -16'sd7);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: program_regs(16'd7680, 16'd128, 16'd2560, 16'd2,
                                16'd15000, 16'd4000, 16'd5000, 16'd20000);
                1: program_regs(16'hffff, 16'hffff, 16'hffff, 16'd0,
                                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
                2: program_regs(16'd0, 16'd0, 16'd0, 16'd0,
                                16'd0, 16'd0, 16'd0, 16'd0);
                3: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'hffff,
                                16'hffff, 16'hffff, 16'hffff, 16'hffff);
                default: program_regs(16'($urandom_range(4096)), 16'($urandom_range(1024)),
                                      16'($urandom), 16'($urandom_range(40)),
                                      16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom));
            endcase

            // idle mix: sender light / receiver heavy, swapped, then none
            if (ph < 2)
            begin
                send_idle_pct  = 24;
                recv_stall_pct = 77;
            end
            else if (ph < 4)
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 24;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            hold_target = 16'($urandom);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n == WORDS_PER_PHASE / 2)
                begin
                    drain();
                    hold_target = 16'($urandom);
                end
                send_random();
            end
        end

        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== pid_speed_controller_unit.f =====
+incdir+rtl
rtl/pidsc_pkg.sv
rtl/pidsc_law.sv
rtl/pid_speed_controller_unit.sv
dv/pidsc_checker.sv
dv/tb.sv
